// ===== src/fermionic_excitation_basis_map_macros.svh =====
// Assertion macros used by the checker file of the excitation basis map.
// Depends on nothing; included by febm_checker.sv.
`ifndef FERMIONIC_EXCITATION_BASIS_MAP_MACROS_SVH
`define FERMIONIC_EXCITATION_BASIS_MAP_MACROS_SVH

// same-cycle implication
`define FEBM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("febm: check failed");

// next-cycle implication
`define FEBM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("febm: check failed");

`endif

// ===== src/febm_pkg.sv =====
// Types, register codes and rounding helper for the excitation basis map.
// Depends on nothing; used by febm_term, febm_out and the top level.
package febm_pkg;

	localparam int WORK_BITS  = 64;
	localparam int ORB_W      = 6;
	localparam int LIST_SLOTS = 4;
	localparam int COUNT_W    = 3;
	localparam int LIST_W     = LIST_SLOTS * ORB_W;
	localparam int AMP_W      = 32;
	localparam int COS_W      = 15;
	localparam int FAC_W      = 32;
	localparam int HALF_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int SUM_W      = 50;

	localparam logic [CFG_IDX_W-1:0] REG_CREATE_COUNT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ANNIHILATE_COUNT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CREATE_LIST      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ANNIHILATE_LIST  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COS_HALF         = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_FORWARD_FACTOR   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ADJOINT_FACTOR   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_BYPASS           = 3'd7;

	localparam logic signed [COS_W-1:0] COS_RESET = 15'sd16383;

	typedef struct packed {
		logic                 a_acts;
		logic                 ad_acts;
		logic                 phase;
		logic [WORK_BITS-1:0] partner;
	} term_t;

	typedef struct packed {
		logic [WORK_BITS-1:0] pattern;
		logic [AMP_W-1:0]     re;
		logic [AMP_W-1:0]     im;
	} word_t;

	// Q1.30 from an exact product: add half an LSB, floor shift by 14, saturate
	function automatic logic [AMP_W-1:0] to_q30(input logic signed [SUM_W-1:0] p);
		logic signed [SUM_W-1:0]    t;
		logic signed [SUM_W-15:0]   r;
		logic [AMP_W-1:0]           res;
		t = p + 50'sd8192;
		r = (SUM_W-14)'(t >>> 14);
		if (r > 36'sd2147483647)
			res = 32'h7FFF_FFFF;
		else if (r < -36'sd2147483648)
			res = 32'h8000_0000;
		else
			res = r[AMP_W-1:0];
		return res;
	endfunction

endpackage

// ===== src/febm_term.sv =====
// Term decode: action checks, partner pattern and Jordan-Wigner phase.
// Depends on febm_pkg. Purely combinational.
module febm_term #(
	parameter int OPS = 4
) (
	input  logic [febm_pkg::WORK_BITS-1:0] pattern,
	input  logic [febm_pkg::COUNT_W-1:0]   create_count,
	input  logic [febm_pkg::COUNT_W-1:0]   annihilate_count,
	input  logic [febm_pkg::LIST_W-1:0]    create_list,
	input  logic [febm_pkg::LIST_W-1:0]    annihilate_list,
	output febm_pkg::term_t                term
);

	localparam int SLOTS = febm_pkg::LIST_SLOTS;
	localparam int SEQ   = 2 * SLOTS;

	logic [febm_pkg::ORB_W-1:0]     c_idx [SLOTS];
	logic [febm_pkg::ORB_W-1:0]     a_idx [SLOTS];
	logic [SLOTS-1:0]               c_en, a_en, c_bit, a_bit, c_par, a_par;
	logic [febm_pkg::ORB_W-1:0]     s_idx [SEQ];
	logic [SEQ-1:0]                 s_en, s_par;
	logic                           a_acts, ad_acts, ph, hit;
	logic [febm_pkg::WORK_BITS-1:0] flips;

	always_comb begin
		for (int k = 0; k < SLOTS; k++) begin
			c_idx[k] = create_list[k*febm_pkg::ORB_W +: febm_pkg::ORB_W];
			a_idx[k] = annihilate_list[k*febm_pkg::ORB_W +: febm_pkg::ORB_W];
			c_en[k]  = (k < OPS) && (create_count > febm_pkg::COUNT_W'(k));
			a_en[k]  = (k < OPS) && (annihilate_count > febm_pkg::COUNT_W'(k));
			c_bit[k] = pattern[c_idx[k]];
			a_bit[k] = pattern[a_idx[k]];
			// parity of the original pattern below each orbital
			c_par[k] = ^(pattern & ((64'd1 << c_idx[k]) - 64'd1));
			a_par[k] = ^(pattern & ((64'd1 << a_idx[k]) - 64'd1));
		end
	end

	assign a_acts  = (&(~c_en | ~c_bit)) & (&(~a_en | a_bit));
	assign ad_acts = (&(~c_en | c_bit)) & (&(~a_en | ~a_bit));

	// flip order: annihilated then created when A acts, the reverse otherwise
	always_comb begin
		for (int k = 0; k < SLOTS; k++) begin
			if (a_acts) begin
				s_idx[k] = a_idx[k];         s_en[k] = a_en[k];         s_par[k] = a_par[k];
				s_idx[SLOTS+k] = c_idx[k];   s_en[SLOTS+k] = c_en[k];   s_par[SLOTS+k] = c_par[k];
			end else begin
				s_idx[k] = c_idx[k];         s_en[k] = c_en[k];         s_par[k] = c_par[k];
				s_idx[SLOTS+k] = a_idx[k];   s_en[SLOTS+k] = a_en[k];   s_par[SLOTS+k] = a_par[k];
			end
		end
	end

	// each earlier flip below an orbital toggles the parity seen there
	always_comb begin
		ph  = 1'b0;
		hit = 1'b0;
		for (int j = 0; j < SEQ; j++) begin
			hit = s_par[j];
			for (int i = 0; i < j; i++)
				hit = hit ^ (s_en[i] & (s_idx[i] < s_idx[j]));
			ph = ph ^ (s_en[j] & hit);
		end
	end

	always_comb begin
		flips = '0;
		for (int k = 0; k < SLOTS; k++) begin
			if (c_en[k])
				flips = flips ^ (64'd1 << c_idx[k]);
			if (a_en[k])
				flips = flips ^ (64'd1 << a_idx[k]);
		end
	end

	assign term.a_acts  = a_acts;
	assign term.ad_acts = ad_acts;
	assign term.phase   = ph;
	assign term.partner = pattern ^ flips;

endmodule

// ===== src/febm_out.sv =====
// Result register: holds one entry's one or two words and hands them out in order.
// Depends on febm_pkg.
module febm_out (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load_valid,
	input  logic            load_two,
	input  febm_pkg::word_t load_w0,
	input  febm_pkg::word_t load_w1,
	output logic            load_ok,
	output logic            out_valid,
	input  logic            out_ready,
	output febm_pkg::word_t word,
	output logic            last
);

	logic            valid_q, sel_q, two_q;
	febm_pkg::word_t w0_q, w1_q;

	assign last      = !two_q || sel_q;
	assign out_valid = valid_q;
	assign load_ok   = !valid_q || (out_ready && last);
	assign word      = sel_q ? w1_q : w0_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sel_q   <= 1'b0;
			two_q   <= 1'b0;
		end else if (load_ok) begin
			valid_q <= load_valid;
			sel_q   <= 1'b0;
			two_q   <= load_two;
		end else if (out_ready) begin
			sel_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok && load_valid) begin
			w0_q <= load_w0;
			w1_q <= load_w1;
		end
	end

endmodule

// ===== src/fermionic_excitation_basis_map.sv =====
// Top level of the fermionic excitation basis map: config, input and product stages.
// Depends on febm_pkg, febm_term, febm_out.
//
//  port group | direction | handshake            | payload
//  input      | in        | in_valid / in_ready   | basis_pattern, amp_real, amp_imag
//  result     | out       | out_valid / out_ready | out_pattern, out_real, out_imag, last_of_item
//  config     | in        | cfg_we                | cfg_index, cfg_data
//
// Three register stages (input, products, result); an entry taken at the input passes
// through them in that order. A passed-through entry gives one word, a rotated entry two,
// both through the single result port. Reset empties the stages and loads the
// register reset values. With out_ready low, entries keep entering until all
// three stages hold one.
module fermionic_excitation_basis_map #(
	parameter int MAX_OPS      = 4,
	parameter int PATTERN_BITS = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [PATTERN_BITS-1:0]           basis_pattern,
	input  logic signed [febm_pkg::AMP_W-1:0] amp_real,
	input  logic signed [febm_pkg::AMP_W-1:0] amp_imag,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [PATTERN_BITS-1:0]           out_pattern,
	output logic signed [febm_pkg::AMP_W-1:0] out_real,
	output logic signed [febm_pkg::AMP_W-1:0] out_imag,
	output logic                              last_of_item,
	input  logic                              cfg_we,
	input  logic [febm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [febm_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int OPS = (MAX_OPS < febm_pkg::LIST_SLOTS) ? MAX_OPS : febm_pkg::LIST_SLOTS;

	logic [febm_pkg::COUNT_W-1:0]     create_count_q, annihilate_count_q;
	logic [febm_pkg::LIST_W-1:0]      create_list_q, annihilate_list_q;
	logic signed [febm_pkg::COS_W-1:0] cos_half_q;
	logic [febm_pkg::FAC_W-1:0]       forward_factor_q, adjoint_factor_q;
	logic                             bypass_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			create_count_q     <= '0;
			annihilate_count_q <= '0;
			create_list_q      <= '0;
			annihilate_list_q  <= '0;
			cos_half_q         <= febm_pkg::COS_RESET;
			forward_factor_q   <= '0;
			adjoint_factor_q   <= '0;
			bypass_q           <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				febm_pkg::REG_CREATE_COUNT:     create_count_q     <= cfg_data[febm_pkg::COUNT_W-1:0];
				febm_pkg::REG_ANNIHILATE_COUNT: annihilate_count_q <= cfg_data[febm_pkg::COUNT_W-1:0];
				febm_pkg::REG_CREATE_LIST:      create_list_q      <= cfg_data[febm_pkg::LIST_W-1:0];
				febm_pkg::REG_ANNIHILATE_LIST:  annihilate_list_q  <= cfg_data[febm_pkg::LIST_W-1:0];
				febm_pkg::REG_COS_HALF:         cos_half_q         <= cfg_data[febm_pkg::COS_W-1:0];
				febm_pkg::REG_FORWARD_FACTOR:   forward_factor_q   <= cfg_data;
				febm_pkg::REG_ADJOINT_FACTOR:   adjoint_factor_q   <= cfg_data;
				febm_pkg::REG_BYPASS:           bypass_q           <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// stage handshake
	logic valid_s1, valid_s2, s2_ready, load_ok;

	assign s2_ready = !valid_s2 || load_ok;
	assign in_ready = !valid_s1 || s2_ready;

	// input stage
	logic [febm_pkg::WORK_BITS-1:0]    pat_s1;
	logic signed [febm_pkg::AMP_W-1:0] ar_s1, ai_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (in_ready)
			valid_s1 <= in_valid;
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pat_s1 <= febm_pkg::WORK_BITS'(basis_pattern);
			ar_s1  <= amp_real;
			ai_s1  <= amp_imag;
		end
	end

	febm_pkg::term_t term;

	febm_term #(
		.OPS(OPS)
	) u_term (
		.pattern          (pat_s1),
		.create_count     (create_count_q),
		.annihilate_count (annihilate_count_q),
		.create_list      (create_list_q),
		.annihilate_list  (annihilate_list_q),
		.term             (term)
	);

	logic [febm_pkg::FAC_W-1:0]         fac;
	logic signed [febm_pkg::HALF_W-1:0] fr, fi;

	assign fac = term.a_acts ? forward_factor_q : adjoint_factor_q;
	assign fr  = fac[febm_pkg::FAC_W-1:febm_pkg::HALF_W];
	assign fi  = fac[febm_pkg::HALF_W-1:0];

	// product stage
	logic [febm_pkg::WORK_BITS-1:0]    pat_s2, partner_s2;
	logic                              phase_s2, pass_s2;
	logic signed [febm_pkg::AMP_W-1:0] ar_s2, ai_s2;
	logic signed [46:0]                cr_s2, ci_s2;
	logic signed [47:0]                prr_s2, pii_s2, pri_s2, pir_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (s2_ready)
			valid_s2 <= valid_s1;
	end

	always_ff @(posedge clk) begin
		if (s2_ready && valid_s1) begin
			pat_s2     <= pat_s1;
			partner_s2 <= term.partner;
			phase_s2   <= term.phase;
			pass_s2    <= bypass_q || (!term.a_acts && !term.ad_acts);
			ar_s2      <= ar_s1;
			ai_s2      <= ai_s1;
			cr_s2      <= ar_s1 * cos_half_q;
			ci_s2      <= ai_s1 * cos_half_q;
			prr_s2     <= fr * ar_s1;
			pii_s2     <= fi * ai_s1;
			pri_s2     <= fr * ai_s1;
			pir_s2     <= fi * ar_s1;
		end
	end

	// sign applied by operand order, then rounding into the result register
	logic signed [febm_pkg::SUM_W-1:0] re_sum, im_sum;
	febm_pkg::word_t                   w0, w1, word;

	always_comb begin
		if (phase_s2) begin
			re_sum = febm_pkg::SUM_W'(pii_s2) - febm_pkg::SUM_W'(prr_s2);
			im_sum = -febm_pkg::SUM_W'(pri_s2) - febm_pkg::SUM_W'(pir_s2);
		end else begin
			re_sum = febm_pkg::SUM_W'(prr_s2) - febm_pkg::SUM_W'(pii_s2);
			im_sum = febm_pkg::SUM_W'(pri_s2) + febm_pkg::SUM_W'(pir_s2);
		end
		w0.pattern = pat_s2;
		w0.re      = pass_s2 ? ar_s2 : febm_pkg::to_q30(febm_pkg::SUM_W'(cr_s2));
		w0.im      = pass_s2 ? ai_s2 : febm_pkg::to_q30(febm_pkg::SUM_W'(ci_s2));
		w1.pattern = partner_s2;
		w1.re      = febm_pkg::to_q30(re_sum);
		w1.im      = febm_pkg::to_q30(im_sum);
	end

	febm_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s2),
		.load_two   (!pass_s2),
		.load_w0    (w0),
		.load_w1    (w1),
		.load_ok    (load_ok),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.word       (word),
		.last       (last_of_item)
	);

	assign out_pattern = word.pattern[PATTERN_BITS-1:0];
	assign out_real    = word.re;
	assign out_imag    = word.im;

endmodule

// ===== src/febm_checker.sv =====
// Port-level checks of the excitation basis map, bound to the top level.
// Depends on fermionic_excitation_basis_map_macros.svh and the top level's ports.
`include "fermionic_excitation_basis_map_macros.svh"

module febm_checker #(
	parameter int PATTERN_BITS = 64
) (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [PATTERN_BITS-1:0] out_pattern,
	input logic [31:0]             out_real,
	input logic [31:0]             out_imag,
	input logic                    last_of_item
);

	// a stalled word holds
	`FEBM_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_pattern) && $stable(out_real) && $stable(out_imag) && $stable(last_of_item))

	// the partner word follows the cos word at once
	`FEBM_ASSERT_NEXT(a_pair_follows, clk, arst_n, out_valid && out_ready && !last_of_item, out_valid && last_of_item)

	// input only backs up behind a waiting word
	`FEBM_ASSERT_IMPLY(a_stall_cause, clk, arst_n, !in_ready, out_valid)

	// nothing leaves straight out of reset
	`FEBM_ASSERT_IMPLY(a_reset_empty, clk, arst_n, $rose(arst_n), !out_valid && in_ready)

	// nor in the cycle after: no entry can have reached the result register yet
	`FEBM_ASSERT_NEXT(a_empty_after_reset, clk, arst_n, $rose(arst_n), !out_valid)

endmodule

bind fermionic_excitation_basis_map febm_checker #(
	.PATTERN_BITS(PATTERN_BITS)
) u_febm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.out_pattern  (out_pattern),
	.out_real     (out_real),
	.out_imag     (out_imag),
	.last_of_item (last_of_item)
);
